[hdl/pcl_pkg.sv]
// shared types and constants of the positional circular list
`default_nettype none

package pcl_pkg;

    localparam int VAL_W = 32;
    localparam int CNT_W = 7;
    localparam int POS_W = 7;

    typedef enum logic [2:0] {
        MODE_INS_FIRST = 3'd0,
        MODE_INS_LAST  = 3'd1,
        MODE_INS_POS   = 3'd2,
        MODE_DEL_FIRST = 3'd3,
        MODE_DEL_LAST  = 3'd4,
        MODE_DEL_POS   = 3'd5,
        MODE_READOUT   = 3'd6,
        MODE_COUNT     = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

endpackage

`default_nettype wire

[hdl/pcl_in_if.sv]
// request channel: one operation per item
`default_nettype none

interface pcl_in_if;
    logic                             valid;
    logic                             ready;
    logic [2:0]                       mode;
    logic signed [pcl_pkg::VAL_W-1:0] item_value;
    logic [pcl_pkg::POS_W-1:0]        position;

    modport source (output valid, output mode, output item_value, output position,
                    input ready);
    modport sink   (input valid, input mode, input item_value, input position,
                    output ready);
endinterface

`default_nettype wire

[hdl/pcl_out_if.sv]
// result channel: status, count and readout values
`default_nettype none

interface pcl_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [pcl_pkg::VAL_W-1:0] out_value;
    logic [1:0]                       status;
    logic [pcl_pkg::CNT_W-1:0]        entry_total;
    logic                             last_of_run;

    modport source (output valid, output out_value, output status, output entry_total,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_value, input status, input entry_total,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

[hdl/positional_circular_list.sv]
// top level: operation sequencer and output register around the list storage
//
//  channel | dir | payload                                      | handshake
//  req     | in  | mode, item_value, position                   | valid/ready
//  rsp     | out | out_value, status, entry_total, last_of_run  | valid/ready
//
// ready is high only while the sequencer is idle; one item at a time
// busy after accept: insert moves the entries from the target on one place up, then
// writes the item; delete moves later entries one place down; readout reads each entry
// each shift step is one read then one write through the single storage port pair
// reset clears the count and the sequencer; storage is not cleared
// a stalled result holds the sequencer, the held result is kept in the output register
`default_nettype none

module positional_circular_list #(
    parameter int CAPACITY = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    pcl_in_if.sink   req,
    pcl_out_if.source rsp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = pcl_pkg::CNT_W;
    localparam int VAL_W = pcl_pkg::VAL_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_MOVE,
        S_RO_RD,
        S_RO_OUT,
        S_RESP
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     ptr_reg, ptr_next;
    logic [IDX_W-1:0]     tgt_reg, tgt_next;
    logic                 ins_reg, ins_next;
    logic [VAL_W-1:0]     val_reg, val_next;
    pcl_pkg::status_t     pend_reg, pend_next;

    logic                 out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]     out_value_reg, out_value_next;
    pcl_pkg::status_t     out_status_reg, out_status_next;
    logic [CNT_W-1:0]     out_total_reg, out_total_next;
    logic                 out_last_reg, out_last_next;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [VAL_W-1:0]     wr_data;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [VAL_W-1:0]     rd_data;

    logic                 in_fire;
    logic                 out_free;
    logic [CNT_W-1:0]     ptr_ext;
    logic [CNT_W-1:0]     pos_less;
    pcl_pkg::mode_t       mode_in;

    pcl_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign in_fire   = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign ptr_ext   = {{(CNT_W-IDX_W){1'b0}}, ptr_reg};
    assign pos_less  = req.position - CNT_W'(1);
    assign mode_in   = pcl_pkg::mode_t'(req.mode);

    assign rsp.valid       = out_valid_reg;
    assign rsp.out_value   = out_value_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_total = out_total_reg;
    assign rsp.last_of_run = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        tgt_next        = tgt_reg;
        ins_next        = ins_reg;
        val_next        = val_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_total_next  = out_total_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        wr_addr         = ptr_reg;
        wr_data         = rd_data;
        rd_en           = 1'b0;
        rd_addr         = ptr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    val_next  = req.item_value;
                    pend_next = pcl_pkg::ST_OK;
                    case (mode_in)
                        pcl_pkg::MODE_INS_FIRST, pcl_pkg::MODE_INS_LAST,
                        pcl_pkg::MODE_INS_POS:
                        begin
                            ins_next = 1'b1;
                            ptr_next = count_reg[IDX_W-1:0];
                            if (count_reg >= CAP_CNT)
                            begin
                                pend_next  = pcl_pkg::ST_FULL;
                                state_next = S_RESP;
                            end
                            else if (mode_in == pcl_pkg::MODE_INS_FIRST)
                            begin
                                tgt_next   = '0;
                                state_next = S_STEP;
                            end
                            else if (mode_in == pcl_pkg::MODE_INS_LAST)
                            begin
                                tgt_next   = count_reg[IDX_W-1:0];
                                state_next = S_STEP;
                            end
                            else if (req.position == '0 || req.position > count_reg + CNT_W'(1))
                            begin
                                pend_next  = pcl_pkg::ST_INVALID;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                tgt_next   = pos_less[IDX_W-1:0];
                                state_next = S_STEP;
                            end
                        end
                        pcl_pkg::MODE_DEL_FIRST, pcl_pkg::MODE_DEL_LAST,
                        pcl_pkg::MODE_DEL_POS:
                        begin
                            ins_next = 1'b0;
                            if (count_reg == '0)
                            begin
                                pend_next  = pcl_pkg::ST_EMPTY;
                                state_next = S_RESP;
                            end
                            else if (mode_in == pcl_pkg::MODE_DEL_FIRST)
                            begin
                                ptr_next   = '0;
                                state_next = S_STEP;
                            end
                            else if (mode_in == pcl_pkg::MODE_DEL_LAST)
                            begin
                                ptr_next   = IDX_W'(count_reg - CNT_W'(1));
                                state_next = S_STEP;
                            end
                            else if (req.position == '0 || req.position > count_reg)
                            begin
                                pend_next  = pcl_pkg::ST_INVALID;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                ptr_next   = pos_less[IDX_W-1:0];
                                state_next = S_STEP;
                            end
                        end
                        pcl_pkg::MODE_READOUT:
                        begin
                            ptr_next = '0;
                            if (count_reg == '0)
                            begin
                                pend_next  = pcl_pkg::ST_EMPTY;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_RO_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_STEP:
            begin
                if (ins_reg)
                begin
                    if (ptr_reg > tgt_reg)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = ptr_reg - IDX_W'(1);
                        state_next = S_MOVE;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = tgt_reg;
                        wr_data    = val_reg;
                        count_next = count_reg + CNT_W'(1);
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    if (ptr_ext + CNT_W'(1) < count_reg)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = ptr_reg + IDX_W'(1);
                        state_next = S_MOVE;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_RESP;
                    end
                end
            end
            S_MOVE:
            begin
                // entry fetched last cycle lands one place along
                wr_en      = 1'b1;
                wr_addr    = ptr_reg;
                wr_data    = rd_data;
                ptr_next   = ins_reg ? ptr_reg - IDX_W'(1) : ptr_reg + IDX_W'(1);
                state_next = S_STEP;
            end
            S_RO_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = ptr_reg;
                state_next = S_RO_OUT;
            end
            S_RO_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = rd_data;
                    out_status_next = pcl_pkg::ST_OK;
                    out_total_next  = count_reg;
                    out_last_next   = (ptr_ext + CNT_W'(1) == count_reg);
                    if (ptr_ext + CNT_W'(1) == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + IDX_W'(1);
                        state_next = S_RO_RD;
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = '0;
                    out_status_next = pend_reg;
                    out_total_next  = count_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            ptr_reg        <= '0;
            tgt_reg        <= '0;
            ins_reg        <= 1'b0;
            val_reg        <= '0;
            pend_reg       <= pcl_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= pcl_pkg::ST_OK;
            out_total_reg  <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
            tgt_reg        <= tgt_next;
            ins_reg        <= ins_next;
            val_reg        <= val_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
            out_total_reg  <= out_total_next;
            out_last_reg   <= out_last_next;
        end
    end

    // count never runs past the storage depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    // count moves by at most one per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CNT_W'(1))
        || (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("entry count jumped");

    // a full status is only reported on a full list
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == pcl_pkg::ST_FULL) |-> (out_total_reg == CAP_CNT))
        else $error("full status on a list with room");

    // a result that is not the last of its run only comes from readout
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> (state_reg == S_RO_RD || state_reg == S_RO_OUT))
        else $error("non-final result outside readout");

endmodule

`default_nettype wire

[hdl/pcl_mem.sv]
// list storage: one write port, one registered read port
`default_nettype none

module pcl_mem #(
    parameter int DEPTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [pcl_pkg::VAL_W-1:0]                  wr_data,
    input  wire logic                                       rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [pcl_pkg::VAL_W-1:0]                       rd_data
);

    logic [pcl_pkg::VAL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[test/tb.sv]
// testbench for the positional circular list: random and directed items against a queue model
`timescale 1ns / 1ps

module tb;

    localparam int CAPACITY = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic signed [pcl_pkg::VAL_W-1:0] value;
        logic [1:0]                       status;
        logic [pcl_pkg::CNT_W-1:0]        total;
        logic                             last;
    } list_result_t;

    class list_scoreboard;
        logic signed [pcl_pkg::VAL_W-1:0] entries[$];
        list_result_t                     awaited[$];
        int                               mismatches = 0;

        function void push_result(logic signed [pcl_pkg::VAL_W-1:0] v,
                                  pcl_pkg::status_t st, logic last);
            list_result_t r;
            r.value  = v;
            r.status = st;
            r.total  = pcl_pkg::CNT_W'(entries.size());
            r.last   = last;
            awaited.push_back(r);
        endfunction

        function void note_request(pcl_pkg::mode_t m, logic signed [pcl_pkg::VAL_W-1:0] v,
                                   logic [pcl_pkg::POS_W-1:0] p);
            pcl_pkg::status_t st;
            int               n;
            st = pcl_pkg::ST_OK;
            n  = entries.size();
            case (m)
                pcl_pkg::MODE_INS_FIRST, pcl_pkg::MODE_INS_LAST, pcl_pkg::MODE_INS_POS:
                begin
                    if (n >= CAPACITY)
                        st = pcl_pkg::ST_FULL;
                    else if (m == pcl_pkg::MODE_INS_FIRST)
                        entries.push_front(v);
                    else if (m == pcl_pkg::MODE_INS_LAST)
                        entries.push_back(v);
                    else if (int'(p) < 1 || int'(p) > n + 1)
                        st = pcl_pkg::ST_INVALID;
                    else
                        entries.insert(int'(p) - 1, v);
                end
                pcl_pkg::MODE_DEL_FIRST, pcl_pkg::MODE_DEL_LAST, pcl_pkg::MODE_DEL_POS:
                begin
                    if (n == 0)
                        st = pcl_pkg::ST_EMPTY;
                    else if (m == pcl_pkg::MODE_DEL_FIRST)
                        entries.delete(0);
                    else if (m == pcl_pkg::MODE_DEL_LAST)
                        entries.delete(n - 1);
                    else if (int'(p) < 1 || int'(p) > n)
                        st = pcl_pkg::ST_INVALID;
                    else
                        entries.delete(int'(p) - 1);
                end
                pcl_pkg::MODE_READOUT:
                begin
                    if (n == 0)
                        push_result('0, pcl_pkg::ST_EMPTY, 1'b1);
                    for (int i = 0; i < n; i++)
                        push_result(entries[i], pcl_pkg::ST_OK, i == n - 1);
                    return;
                end
                default:
                begin
                end
            endcase
            push_result('0, st, 1'b1);
        endfunction

        function void check_result(list_result_t got);
            list_result_t want;
            if (awaited.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: value %0d status %0d total %0d last %0d",
                             got.value, got.status, got.total, got.last);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (got.value !== want.value || got.status !== want.status ||
                got.total !== want.total || got.last !== want.last)
            begin
                if (mismatches < 10)
                begin
                    $display("mismatch: expected value %0d status %0d total %0d last %0d",
                             want.value, want.status, want.total, want.last);
                    $display("          got value %0d status %0d total %0d last %0d",
                             got.value, got.status, got.total, got.last);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   gap_pct;
    int   stall_pct;
    int   cycle_count = 0;

    list_scoreboard sb = new;

    pcl_in_if  req ();
    pcl_out_if rsp ();

    positional_circular_list #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req.sink),
        .rsp  (rsp.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
        rsp.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        list_result_t got;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got.value  = rsp.out_value;
            got.status = rsp.status;
            got.total  = rsp.entry_total;
            got.last   = rsp.last_of_run;
            sb.check_result(got);
        end
    end

    task automatic send_item(pcl_pkg::mode_t m, int v, int p);
        if ($urandom_range(99) < gap_pct)
        begin
            req.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        req.valid      <= 1'b1;
        req.mode       <= m;
        req.item_value <= v;
        req.position   <= pcl_pkg::POS_W'(p);
        do
            @(posedge clk);
        while (!req.ready);
        sb.note_request(m, v, pcl_pkg::POS_W'(p));
    endtask

    // trend 0 grows the list, 1 shrinks it, 2 is balanced
    task automatic random_item(int trend);
        int             n;
        int             r;
        int             ins_pct;
        pcl_pkg::mode_t m;
        int             v;
        int             p;
        n       = sb.entries.size();
        r       = $urandom_range(99);
        ins_pct = (trend == 0) ? 75 : (trend == 1) ? 15 : 45;
        if (r < ins_pct)
            m = pcl_pkg::mode_t'($urandom_range(2));
        else if (r < 90)
            m = pcl_pkg::mode_t'($urandom_range(5, 3));
        else
            m = pcl_pkg::mode_t'($urandom_range(7, 6));
        if ($urandom_range(99) < 15)
            p = $urandom_range(65);
        else if (m == pcl_pkg::MODE_INS_POS)
            p = $urandom_range(n + 1, 1);
        else
            p = $urandom_range((n == 0) ? 1 : n, 1);
        case ($urandom_range(9))
            0: v = 32'sh8000_0000;
            1: v = 32'sh7fff_ffff;
            default: v = $urandom();
        endcase
        send_item(m, v, p);
    endtask

    initial
    begin
        int trend;
        gap_pct        = 0;
        stall_pct      = 0;
        rst_n          <= 1'b0;
        req.valid      <= 1'b0;
        req.mode       <= pcl_pkg::MODE_COUNT;
        req.item_value <= '0;
        req.position   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list cases
        send_item(pcl_pkg::MODE_COUNT, 0, 0);
        send_item(pcl_pkg::MODE_READOUT, 0, 0);
        send_item(pcl_pkg::MODE_DEL_FIRST, 0, 0);
        send_item(pcl_pkg::MODE_DEL_LAST, 0, 0);
        send_item(pcl_pkg::MODE_DEL_POS, 0, 1);
        send_item(pcl_pkg::MODE_DEL_POS, 0, 65);
        send_item(pcl_pkg::MODE_INS_POS, 5, 0);
        send_item(pcl_pkg::MODE_INS_POS, 5, 2);
        // build and shape a short list
        send_item(pcl_pkg::MODE_INS_POS, 32'sh8000_0000, 1);
        send_item(pcl_pkg::MODE_INS_FIRST, 32'sh7fff_ffff, 0);
        send_item(pcl_pkg::MODE_INS_LAST, -1, 0);
        send_item(pcl_pkg::MODE_INS_POS, 0, 2);
        send_item(pcl_pkg::MODE_INS_POS, 32'sh5a5a_a5a5, 5);
        send_item(pcl_pkg::MODE_INS_POS, 7, 7);
        send_item(pcl_pkg::MODE_READOUT, 0, 0);
        send_item(pcl_pkg::MODE_DEL_POS, 0, 0);
        send_item(pcl_pkg::MODE_DEL_POS, 0, 6);
        send_item(pcl_pkg::MODE_DEL_POS, 0, 64);
        send_item(pcl_pkg::MODE_DEL_POS, 0, 3);
        send_item(pcl_pkg::MODE_DEL_POS, 0, 4);
        send_item(pcl_pkg::MODE_DEL_FIRST, 0, 0);
        send_item(pcl_pkg::MODE_DEL_LAST, 0, 0);
        send_item(pcl_pkg::MODE_COUNT, 0, 0);
        send_item(pcl_pkg::MODE_READOUT, 0, 0);

        trend = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 59; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 59; end
                default: begin gap_pct = 37; stall_pct = 37; end
            endcase
            for (int k = 0; k < 19; k++)
            begin
                if (k % 10 == 0)
                    trend = $urandom_range(2);
                random_item(trend);
            end
        end
        req.valid <= 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
